### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

   // Field widths
   localparam int HUE_W  = 16;
   localparam int CH_W   = 8;
   localparam int FRAC_W = 16;
   localparam int X_W    = FRAC_W + 1;
   localparam int LO_W   = 8;

   // Fixed-point one for the channel fraction
   localparam logic [X_W-1:0] ONE_X = 17'h10000;

   // Reciprocal multipliers (exact over the ranges used; RECIP_255 is a low estimate)
   localparam logic [14:0] RECIP_DEG15  = 15'd17477;   // e/15, e < 2^14, shift 18
   localparam logic [15:0] RECIP_SIX    = 16'd43691;   // q/6, q < 1093, shift 18
   localparam logic [19:0] RECIP_FRAC15 = 20'd559241;  // e/15, e < 2^20, shift 23
   localparam logic [16:0] RECIP_255    = 17'd65793;   // low estimate of P/255, shift 24

   // Channel lane latency in cycles
   localparam int CHAN_LAT = 4;

   // Sector codes: arrangement of (red, green, blue)
   localparam logic [2:0] SECT_VTP = 3'd0;
   localparam logic [2:0] SECT_QVP = 3'd1;
   localparam logic [2:0] SECT_PVT = 3'd2;
   localparam logic [2:0] SECT_PQV = 3'd3;
   localparam logic [2:0] SECT_TPV = 3'd4;
   localparam logic [2:0] SECT_VPQ = 3'd5;

   // Sector front end result
   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [2:0]        idx;
      logic [FRAC_W-1:0] f16;
      logic [CH_W-1:0]   sat;
      logic [CH_W-1:0]   val;
   } sect_type;

   // Side band that travels beside the channel lanes
   typedef struct packed {
      logic       zero;
      logic [2:0] idx;
   } side_type;

endpackage

### src/hsv2rgb_sector.sv
`timescale 1ns / 1ps

module hsv2rgb_sector
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [HUE_W-1:0] hue,
   input  logic [CH_W-1:0]  sat,
   input  logic [CH_W-1:0]  val,
   output sect_type         sect
);

   localparam logic [LO_W-1:0] LO_MASK = LO_W'((1 << HUE_FRAC_BITS) - 1);

   // Stage 1: whole degrees, degrees / 60
   logic [HUE_W-1:0] deg_in;
   logic [28:0]      prod1;
   logic [10:0]      q60_in;
   logic [LO_W-1:0]  lo_in;

   logic             s1_valid_ff;
   logic [HUE_W-1:0] s1_deg_ff;
   logic [10:0]      s1_q60_ff;
   logic [LO_W-1:0]  s1_lo_ff;
   logic [CH_W-1:0]  s1_sat_ff;
   logic [CH_W-1:0]  s1_val_ff;

   assign deg_in = HUE_W'(hue >> HUE_FRAC_BITS);
   assign prod1  = 29'(deg_in[HUE_W-1:2]) * 29'(RECIP_DEG15);
   assign q60_in = prod1[28:18];
   assign lo_in  = hue[LO_W-1:0] & LO_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_deg_ff <= deg_in;
         s1_q60_ff <= q60_in;
         s1_lo_ff  <= lo_in;
         s1_sat_ff <= sat;
         s1_val_ff <= val;
      end
   end

   // Stage 2: degrees mod 60, sector count / 6
   logic [HUE_W-1:0] r60_full;
   logic [5:0]       r60_in;
   logic [26:0]      prod2;
   logic [8:0]       q6_in;

   logic             s2_valid_ff;
   logic [5:0]       s2_r60_ff;
   logic [10:0]      s2_q60_ff;
   logic [8:0]       s2_q6_ff;
   logic [LO_W-1:0]  s2_lo_ff;
   logic [CH_W-1:0]  s2_sat_ff;
   logic [CH_W-1:0]  s2_val_ff;

   assign r60_full = s1_deg_ff - HUE_W'(HUE_W'(s1_q60_ff) * HUE_W'(60));
   assign r60_in   = r60_full[5:0];
   assign prod2    = 27'(s1_q60_ff) * 27'(RECIP_SIX);
   assign q6_in    = prod2[26:18];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_r60_ff <= r60_in;
         s2_q60_ff <= s1_q60_ff;
         s2_q6_ff  <= q6_in;
         s2_lo_ff  <= s1_lo_ff;
         s2_sat_ff <= s1_sat_ff;
         s2_val_ff <= s1_val_ff;
      end
   end

   // Stage 3: sector index and 16-bit fraction within the sector
   logic [10:0]      idx_full;
   logic [23:0]      num;
   logic [19:0]      e2;
   logic [39:0]      prod3;
   sect_type         sect_in;
   logic             s3_valid_ff;
   sect_type         s3_ff;

   assign idx_full = s2_q60_ff - 11'(11'(s2_q6_ff) * 11'(6));
   assign num      = {2'b00, s2_r60_ff, 16'h0000}
                   | (24'({s2_lo_ff, 16'h0000}) >> HUE_FRAC_BITS);
   assign e2       = num[21:2];
   assign prod3    = 40'(e2) * 40'(RECIP_FRAC15);

   always_comb begin
      sect_in       = '0;
      sect_in.valid = s2_valid_ff;
      sect_in.zero  = (s2_sat_ff == '0);
      sect_in.idx   = idx_full[2:0];
      sect_in.f16   = prod3[38:23];
      sect_in.sat   = s2_sat_ff;
      sect_in.val   = s2_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= sect_in;
      end
   end

   always_comb begin
      sect       = s3_ff;
      sect.valid = s3_valid_ff;
   end

endmodule

### src/hsv2rgb_chan.sv
`timescale 1ns / 1ps

module hsv2rgb_chan
   import hsv2rgb_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [CH_W-1:0] sat,
   input  logic [CH_W-1:0] val,
   input  logic [X_W-1:0]  x,
   output logic [CH_W-1:0] chan
);

   // Stage 1: s * x
   logic [24:0]     prod_in;
   logic [24:0]     c1_prod_ff;
   logic [CH_W-1:0] c1_val_ff;

   assign prod_in = 25'(sat) * 25'(x);

   always_ff @(posedge clock) begin
      if (en) begin
         c1_prod_ff <= prod_in;
         c1_val_ff  <= val;
      end
   end

   // Stage 2: low estimate of product / 255 (shift-add reciprocal)
   logic [40:0]     recip_sum;
   logic [X_W-1:0]  q0_in;
   logic [X_W-1:0]  c2_q0_ff;
   logic [24:0]     c2_prod_ff;
   logic [CH_W-1:0] c2_val_ff;

   assign recip_sum = (41'(c1_prod_ff) << 16) + (41'(c1_prod_ff) << 8) + 41'(c1_prod_ff);
   assign q0_in     = recip_sum[40:24];

   always_ff @(posedge clock) begin
      if (en) begin
         c2_q0_ff   <= q0_in;
         c2_prod_ff <= c1_prod_ff;
         c2_val_ff  <= c1_val_ff;
      end
   end

   // Stage 3: one-step correction, then 1 - s*x
   logic [24:0]     rem;
   logic [X_W-1:0]  sx;
   logic [X_W-1:0]  om_in;
   logic [X_W-1:0]  c3_om_ff;
   logic [CH_W-1:0] c3_val_ff;

   assign rem   = c2_prod_ff - 25'(25'(c2_q0_ff) * 25'(255));
   assign sx    = c2_q0_ff + X_W'(rem >= 25'(255));
   assign om_in = ONE_X - sx;

   always_ff @(posedge clock) begin
      if (en) begin
         c3_om_ff  <= om_in;
         c3_val_ff <= c2_val_ff;
      end
   end

   // Stage 4: v * (1 - s*x), keep the integer part
   logic [24:0]     scaled;
   logic [CH_W-1:0] c4_chan_ff;

   assign scaled = 25'(c3_val_ff) * 25'(c3_om_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         c4_chan_ff <= scaled[23:16];
      end
   end

   assign chan = c4_chan_ff;

endmodule

### src/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter. Takes one word per clock on req_ (hue in 1/2^HUE_FRAC_BITS
// degree units, wrapped at 360 degrees; saturation and brightness as fractions of 255)
// and returns 8-bit red, green and blue on rsp_, truncated; zero saturation gives
// black. Fully pipelined (3 sector stages, 4 channel-lane stages, 1 output register),
// one word per clock sustained while rsp_ words are taken. When the output register
// holds a word that is not taken, the whole pipeline freezes and req_tready drops;
// nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_to_rgb_converter_unit
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   // Pipeline advance
   logic en;
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Sector front end
   sect_type sect;

   hsv2rgb_sector #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_sector (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .hue      (req_tdata[15:0]),
      .sat      (req_tdata[23:16]),
      .val      (req_tdata[31:24]),
      .sect     (sect)
   );

   // Channel lanes: p, q, t
   logic [X_W-1:0]  x_q;
   logic [X_W-1:0]  x_t;
   logic [CH_W-1:0] ch_p;
   logic [CH_W-1:0] ch_q;
   logic [CH_W-1:0] ch_t;

   assign x_q = X_W'(sect.f16);
   assign x_t = ONE_X - X_W'(sect.f16);

   hsv2rgb_chan u_chan_p (
      .clock (clock),
      .en    (en),
      .sat   (sect.sat),
      .val   (sect.val),
      .x     (ONE_X),
      .chan  (ch_p)
   );

   hsv2rgb_chan u_chan_q (
      .clock (clock),
      .en    (en),
      .sat   (sect.sat),
      .val   (sect.val),
      .x     (x_q),
      .chan  (ch_q)
   );

   hsv2rgb_chan u_chan_t (
      .clock (clock),
      .en    (en),
      .sat   (sect.sat),
      .val   (sect.val),
      .x     (x_t),
      .chan  (ch_t)
   );

   // Side band delay beside the lanes
   logic            valid_ff [CHAN_LAT];
   side_type        side_ff  [CHAN_LAT];
   logic [CH_W-1:0] v_ff     [CHAN_LAT];
   side_type        side_in;

   assign side_in.zero = sect.zero;
   assign side_in.idx  = sect.idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAN_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= sect.valid;
         for (int i = 1; i < CHAN_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         v_ff[0]    <= sect.val;
         for (int i = 1; i < CHAN_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
            v_ff[i]    <= v_ff[i-1];
         end
      end
   end

   // Sector arrangement and black on zero saturation
   logic [CH_W-1:0] vv;
   logic [CH_W-1:0] red_in;
   logic [CH_W-1:0] green_in;
   logic [CH_W-1:0] blue_in;

   assign vv = v_ff[CHAN_LAT-1];

   always_comb begin
      case (side_ff[CHAN_LAT-1].idx)
         SECT_VTP: begin red_in = vv;   green_in = ch_t; blue_in = ch_p; end
         SECT_QVP: begin red_in = ch_q; green_in = vv;   blue_in = ch_p; end
         SECT_PVT: begin red_in = ch_p; green_in = vv;   blue_in = ch_t; end
         SECT_PQV: begin red_in = ch_p; green_in = ch_q; blue_in = vv;   end
         SECT_TPV: begin red_in = ch_t; green_in = ch_p; blue_in = vv;   end
         default:  begin red_in = vv;   green_in = ch_p; blue_in = ch_q; end
      endcase
      if (side_ff[CHAN_LAT-1].zero) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   // Output register
   logic [23:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_ff[CHAN_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {blue_in, green_in, red_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `ASSERT_ALWAYS(a_ready_when_empty, !rsp_valid_ff |-> req_tready, "ready low with empty output")
   `ASSERT_CLK(a_freeze_lanes, !req_tready |=> $stable(valid_ff[CHAN_LAT-1]) && $stable(vv), "lane moved during stall")
   `ASSERT_CLK(a_freeze_front, !req_tready |=> $stable(sect), "front end moved during stall")

endmodule

### tb/hsv_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_tb;
   import hsv2rgb_pkg::*;

   localparam int HUE_FRAC    = 4;
   localparam int HUE_FULL    = 360 << HUE_FRAC;
   localparam int HUE_SECT    = 60 << HUE_FRAC;
   localparam int PIPE_LAT    = 8;
   localparam int IDLE_PCT    = 11;
   localparam int STALL_LIMIT = 1000;
   localparam int EXP_DEPTH   = 4096;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } rgb_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // hue[15:0], saturation[23:16], brightness[31:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red[7:0], green[15:8], blue[23:16]

   // Expected colors, in order of input accept
   rgb_type expect_mem [EXP_DEPTH];
   int   expect_wr         = 0;
   int   expect_rd         = 0;
   int   mismatch_count    = 0;
   int   quiet_cycles      = 0;
   int   sink_hold_request = 0;
   int   sink_hold_left    = 0;
   bit   steady_flow       = 1'b0;

   hsv_to_rgb_converter_unit #(.HUE_FRAC_BITS(HUE_FRAC)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // brightness * (1 - sat * frac), frac with 16 fractional bits, truncated
   function automatic logic [CH_W-1:0] shade_channel(input logic [CH_W-1:0] bri,
                                                     input logic [CH_W-1:0] sat,
                                                     input logic [X_W-1:0] frac);
      logic [31:0] dim;
      logic [31:0] prod;
      dim = (32'(sat) * 32'(frac)) / 32'd255;
      if (dim > 32'd65536)
         dim = 32'd65536;
      prod = 32'(bri) * (32'd65536 - dim);
      return prod[23:16];
   endfunction

   function automatic rgb_type hsv_to_rgb_predict(input logic [HUE_W-1:0] hue,
                                                  input logic [CH_W-1:0] sat,
                                                  input logic [CH_W-1:0] bri);
      int unsigned     wrapped;
      int unsigned     sector;
      logic [X_W-1:0]  frac;
      logic [CH_W-1:0] p, q, t;
      rgb_type         c;
      c = '0;
      if (sat == 0)
         return c;
      wrapped = hue % HUE_FULL;
      sector  = wrapped / HUE_SECT;
      frac    = X_W'(((wrapped % HUE_SECT) << 16) / HUE_SECT);
      p = shade_channel(bri, sat, ONE_X);
      q = shade_channel(bri, sat, frac);
      t = shade_channel(bri, sat, ONE_X - frac);
      case (3'(sector))
         SECT_VTP: begin c.red = bri; c.green = t;   c.blue = p;   end
         SECT_QVP: begin c.red = q;   c.green = bri; c.blue = p;   end
         SECT_PVT: begin c.red = p;   c.green = bri; c.blue = t;   end
         SECT_PQV: begin c.red = p;   c.green = q;   c.blue = bri; end
         SECT_TPV: begin c.red = t;   c.green = p;   c.blue = bri; end
         default:  begin c.red = bri; c.green = p;   c.blue = q;   end
      endcase
      return c;
   endfunction

   task automatic check_field(input string name, input logic [CH_W-1:0] want,
                              input logic [CH_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Predict on input accept, compare on output accept
   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expect_mem[expect_wr % EXP_DEPTH] = hsv_to_rgb_predict(req_tdata[15:0],
                                                                   req_tdata[23:16],
                                                                   req_tdata[31:24]);
            expect_wr++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expect_rd == expect_wr) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expect_mem[expect_rd % EXP_DEPTH];
               expect_rd++;
               check_field("red",   want.red,   got.red);
               check_field("green", want.green, got.green);
               check_field("blue",  want.blue,  got.blue);
            end
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off on request
   always @(posedge clock) begin
      if (sink_hold_request > 0) begin
         sink_hold_left    = sink_hold_request;
         sink_hold_request = 0;
      end
      if (sink_hold_left > 0) begin
         sink_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_color(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
                             input logic [CH_W-1:0] bri);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bri, sat, hue};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_color();
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  sat;
      // mostly in-range hues, some wrapping; zero saturation now and then
      if ($urandom_range(0, 7) == 0)
         hue = HUE_W'($urandom);
      else
         hue = HUE_W'($urandom_range(0, HUE_FULL - 1));
      sat = ($urandom_range(0, 15) == 0) ? '0 : CH_W'($urandom);
      send_color(hue, sat, CH_W'($urandom));
   endtask

   task automatic wait_for_results();
      while (expect_rd != expect_wr)
         @(posedge clock);
   endtask

   // Extremes, every sector at its start and middle, the end of the first and last, wrap, black
   task automatic test_directed();
      send_color(0, 255, 255);
      send_color(HUE_W'(HUE_SECT - 1), 255, 255);
      send_color(HUE_W'(HUE_SECT), 255, 255);
      send_color(HUE_W'(2 * HUE_SECT), 255, 255);
      send_color(HUE_W'(3 * HUE_SECT), 255, 255);
      send_color(HUE_W'(4 * HUE_SECT), 255, 255);
      send_color(HUE_W'(5 * HUE_SECT), 255, 255);
      send_color(HUE_W'(HUE_FULL - 1), 255, 255);
      send_color(HUE_W'(HUE_FULL), 255, 255);
      send_color(16'hFFFF, 255, 255);
      send_color(HUE_W'(HUE_SECT / 2), 128, 200);
      send_color(HUE_W'(HUE_SECT + HUE_SECT / 2), 77, 180);
      send_color(HUE_W'(2 * HUE_SECT + HUE_SECT / 2), 200, 90);
      send_color(HUE_W'(3 * HUE_SECT + HUE_SECT / 2), 1, 255);
      send_color(HUE_W'(4 * HUE_SECT + HUE_SECT / 2), 254, 17);
      send_color(HUE_W'(5 * HUE_SECT + HUE_SECT / 2), 100, 255);
      send_color(1000, 0, 255);
      send_color(16'hFFFF, 0, 0);
      send_color(3000, 255, 0);
      send_color(0, 0, 0);
      send_color(12345, 1, 1);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_color();
   endtask

   // Full rate on both sides
   task automatic test_steady_run(input int count);
      steady_flow = 1'b1;
      repeat (count) send_random_color();
      steady_flow = 1'b0;
   endtask

   // Output held off while input keeps offering; pipeline fills and stalls
   task automatic test_output_stall(input int hold, input int count);
      sink_hold_request = hold;
      repeat (count) send_random_color();
   endtask

   // Sender stops until every result is back, then resumes
   task automatic test_drain_pause(input int count);
      repeat (count) send_random_color();
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (PIPE_LAT) @(posedge clock);
      repeat (count) send_random_color();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1200);
      test_steady_run(300);
      test_output_stall(80, 60);
      test_drain_pause(40);
      test_random(400);
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (2 * PIPE_LAT) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
